// File: src/chunked_rle_bitmap_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// chunked rle bitmap decoder assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef CHUNKED_RLE_BITMAP_DECODER_UNIT_ASSERT_SVH
`define CHUNKED_RLE_BITMAP_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
// expression must hold at every clock edge out of reset
`define CRBD_ASSERT_HOLD(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("crbd assertion failed");
// antecedent implies consequent in the same cycle
`define CRBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crbd assertion failed");
// antecedent implies consequent in the next cycle
`define CRBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crbd assertion failed");
`else
`define CRBD_ASSERT_HOLD(lbl, expr)
`define CRBD_ASSERT_IMP(lbl, ante, cons)
`define CRBD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/crbd_pkg.sv
// ----------------------------------------------------------------------------
// crbd_pkg
// shared types, constants and helpers of the chunked rle bitmap decoder
// ----------------------------------------------------------------------------
package crbd_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int HALF_ROWS      = (DISPLAY_HEIGHT + 1) / 2;
  localparam int STORE_DEPTH    = 512;
  localparam int ADDR_W         = 9;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 32;

  localparam logic [2:0] MAX_GROUPS = 3'd6;

  localparam logic [0:0] CFG_IMG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IMG_HEIGHT = 1'b1;

  localparam logic KIND_STREAM = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic rd_issue;
    logic take_bit;
    logic paint_rd;
    logic paint_wr;
    logic sync_start;
    logic sync_step;
    logic walk_step;
    logic out_load;
  } crbd_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_kind;
    logic count_done;
    logic count_n;
    logic walk_paint;
    logic walk_end;
  } crbd_stat_t;

  // base of a count coded with g groups
  function automatic logic [15:0] group_offset(input logic [2:0] g);
    logic [15:0] off;
    case (g)
      3'd2:    off = 16'd8;
      3'd3:    off = 16'd72;
      3'd4:    off = 16'd584;
      3'd5:    off = 16'd4680;
      3'd6:    off = 16'd37448;
      default: off = 16'd0;
    endcase
    return off;
  endfunction

endpackage

// File: src/chunked_rle_bitmap_decoder_unit.sv
// ----------------------------------------------------------------------------
// chunked_rle_bitmap_decoder_unit
// changed-chunk run-length decoder painting a 128x64 1-bit framebuffer
// ----------------------------------------------------------------------------
// channel   dir  handshake                fields
// s_*       in   s_tvalid / s_tready      tuser kind, tdata byte/row/word
// m_*       out  m_tvalid / m_tready      tdata read_data/frame_total, tlast done
// cfg_*     in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// after reset the 512-word store is cleared, one word a cycle,
// with s_tready low; cfg writes are taken throughout
// a read item is accepted, read and its result loaded; a stream byte is accepted,
// decoded bit by bit and its result loaded, plus a chunk position sync per
// completed run count, walk steps and a memory read-modify-write per painted pixel
// the next item is taken while a result waits in the output register
// ----------------------------------------------------------------------------
module chunked_rle_bitmap_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] data_byte, [12:8] read_row, [16:13] read_word, rest zero
  input  logic [crbd_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [0] kind
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] read_data, [31:16] frame_total
  output logic [crbd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // frame_done
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [7:0]                        cfg_data
);
  import crbd_pkg::*;

  crbd_cmd_t   cmd;
  crbd_stat_t  stat;
  logic [15:0] read_data;
  logic [15:0] frame_total;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {frame_total, read_data};

  crbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  crbd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (s_tuser),
    .in_byte         (s_tdata[7:0]),
    .in_row          (s_tdata[12:8]),
    .in_word         (s_tdata[16:13]),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_read_data   (read_data),
    .out_frame_done  (m_tlast),
    .out_frame_total (frame_total)
  );

endmodule

// File: src/crbd_dp.sv
// ----------------------------------------------------------------------------
// crbd_dp
// decode state, chunk counters and framebuffer memory
// ----------------------------------------------------------------------------
module crbd_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  crbd_pkg::crbd_cmd_t     cmd,
  output crbd_pkg::crbd_stat_t    stat,
  input  logic                    in_kind,
  input  logic [7:0]              in_byte,
  input  logic [4:0]              in_row,
  input  logic [3:0]              in_word,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [7:0]              cfg_data,
  output logic [15:0]             out_read_data,
  output logic                    out_frame_done,
  output logic [15:0]             out_frame_total
);
  import crbd_pkg::*;

  localparam logic [2:0] PH_MASK    = 3'd0;
  localparam logic [2:0] PH_COLOUR  = 3'd1;
  localparam logic [2:0] PH_UNARY   = 3'd2;
  localparam logic [2:0] PH_BITS    = 3'd3;
  localparam logic [2:0] PH_UNARY_N = 3'd4;
  localparam logic [2:0] PH_BITS_N  = 3'd5;

  logic [7:0]  img_width;
  logic [6:0]  img_height;
  logic [2:0]  decode_phase;
  logic        first_pending;
  logic [63:0] chunk_mask;
  logic [5:0]  mask_bits_seen;
  logic        pixel_value;
  logic [15:0] run_left;
  logic [2:0]  group_count;
  logic [17:0] count_accum;
  logic [4:0]  count_bits_left;
  logic [7:0]  col_x;
  logic [6:0]  row_y;
  logic [7:0]  col_in;
  logic [2:0]  chunk_x;
  logic [6:0]  row_in;
  logic [2:0]  chunk_y;
  logic [15:0] frame_counter;
  logic        frame_flag;
  logic [7:0]  byte_sh;
  logic        kind_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] clr_addr;

  logic [15:0] mem [0:STORE_DEPTH-1];
  logic [15:0] mem_q;
  logic [ADDR_W-1:0] mem_addr;
  logic        mem_we;
  logic        mem_re;
  logic [15:0] mem_wd;

  logic [7:0]  eff_w;
  logic [6:0]  eff_h;
  logic [4:0]  chunk_w;
  logic [3:0]  chunk_h;
  logic [6:0]  x_off;
  logic [5:0]  y_off;
  logic [8:0]  dx;
  logic [7:0]  dy;
  logic        in_bounds;
  logic        lower;
  logic [ADDR_W-1:0] paint_addr;
  logic [15:0] bit_mask;

  logic        bit_in;
  logic [63:0] mask_next;
  logic [17:0] accum_next;
  logic [18:0] run_sum;
  logic        col_ge;
  logic        row_ge;
  logic        skip;
  logic [7:0]  col_in_inc;
  logic [6:0]  row_in_inc;

  // effective size and geometry
  always_comb begin
    eff_w = (img_width == 8'd0) ? 8'd1 : img_width;
    if (img_height == 7'd0) begin
      eff_h = 7'd1;
    end else if (img_height > 7'(DISPLAY_HEIGHT)) begin
      eff_h = 7'(DISPLAY_HEIGHT);
    end else begin
      eff_h = img_height;
    end
    if (eff_w > 8'(DISPLAY_WIDTH)) eff_w = 8'(DISPLAY_WIDTH);
    chunk_w = 5'(((eff_w - 8'd1) >> 3) + 8'd1);
    chunk_h = 4'(((eff_h - 7'd1) >> 3) + 7'd1);
    x_off   = 7'((8'(DISPLAY_WIDTH) - eff_w) >> 1);
    y_off   = 6'((7'(DISPLAY_HEIGHT) - eff_h) >> 1);
  end

  // pixel address, lower half of the display sits to the right
  always_comb begin
    dx         = {1'b0, col_x} + {2'b0, x_off};
    dy         = {1'b0, row_y} + {2'b0, y_off};
    in_bounds  = (dx < 9'(DISPLAY_WIDTH)) && (dy < 8'(DISPLAY_HEIGHT));
    lower      = (dy >= 8'(HALF_ROWS));
    paint_addr = {dy[4:0], lower, dx[6:4]};
    bit_mask   = 16'h8000 >> dx[3:0];
  end

  always_comb begin
    mem_addr = paint_addr;
    if (cmd.clr_wr) begin
      mem_addr = clr_addr;
    end else if (cmd.rd_issue) begin
      mem_addr = rd_addr;
    end
    mem_we = cmd.clr_wr || (cmd.paint_wr && in_bounds);
    mem_re = cmd.rd_issue || cmd.paint_rd;
    if (cmd.clr_wr) begin
      mem_wd = 16'd0;
    end else if (pixel_value) begin
      mem_wd = mem_q | bit_mask;
    end else begin
      mem_wd = mem_q & ~bit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_addr];
  end

  // bit decode and walk status
  always_comb begin
    bit_in     = byte_sh[7];
    mask_next  = ((mask_bits_seen == 6'd0) ? 64'd0 : (chunk_mask << 1)) | {63'd0, bit_in};
    accum_next = {count_accum[16:0], bit_in};
    run_sum    = {1'b0, accum_next} + {3'b0, group_offset(group_count)} + 19'd1;
    col_ge     = ({1'b0, col_x} >= {1'b0, eff_w});
    row_ge     = (row_y >= eff_h);
    skip       = (row_in == 7'd0) && !chunk_mask[{chunk_x, chunk_y}];
    col_in_inc = col_in + 8'd1;
    row_in_inc = row_in + 7'd1;
    stat.clr_last   = (clr_addr == ADDR_W'(STORE_DEPTH - 1));
    stat.in_kind    = kind_q;
    stat.count_done = ((decode_phase == PH_BITS) || (decode_phase == PH_BITS_N))
                      && (count_bits_left <= 5'd1);
    stat.count_n    = (decode_phase == PH_BITS_N);
    stat.walk_end   = col_ge || (!row_ge && !skip && (run_left == 16'd0));
    stat.walk_paint = !col_ge && !row_ge && !skip && (run_left != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_sh <= in_byte;
      rd_addr <= {in_row, in_word};
    end else if (cmd.take_bit) begin
      byte_sh <= {byte_sh[6:0], 1'b0};
    end
    if (cmd.out_load) begin
      out_read_data   <= (kind_q == KIND_READ) ? mem_q : 16'd0;
      out_frame_done  <= frame_flag;
      out_frame_total <= frame_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width       <= 8'd128;
      img_height      <= 7'd64;
      decode_phase    <= PH_MASK;
      first_pending   <= 1'b1;
      chunk_mask      <= 64'd0;
      mask_bits_seen  <= 6'd0;
      pixel_value     <= 1'b0;
      run_left        <= 16'd0;
      group_count     <= 3'd0;
      count_accum     <= 18'd0;
      count_bits_left <= 5'd0;
      col_x           <= 8'd0;
      row_y           <= 7'd0;
      col_in          <= 8'd0;
      chunk_x         <= 3'd0;
      row_in          <= 7'd0;
      chunk_y         <= 3'd0;
      frame_counter   <= 16'd0;
      frame_flag      <= 1'b0;
      kind_q          <= KIND_STREAM;
      clr_addr        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IMG_WIDTH) begin
          img_width <= cfg_data;
        end else begin
          img_height <= cfg_data[6:0];
        end
      end
      if (cmd.clr_wr) clr_addr <= clr_addr + ADDR_W'(1);
      if (cmd.load_in) begin
        kind_q     <= in_kind;
        frame_flag <= 1'b0;
      end
      if (cmd.take_bit) begin
        case (decode_phase)
          PH_COLOUR: begin
            pixel_value  <= bit_in;
            group_count  <= 3'd1;
            decode_phase <= PH_UNARY;
          end
          PH_UNARY, PH_UNARY_N: begin
            if (bit_in) begin
              if (group_count < MAX_GROUPS) group_count <= group_count + 3'd1;
            end else begin
              count_bits_left <= {2'b0, group_count} + {1'b0, group_count, 1'b0};
              count_accum     <= 18'd0;
              decode_phase    <= (decode_phase == PH_UNARY) ? PH_BITS : PH_BITS_N;
            end
          end
          PH_BITS, PH_BITS_N: begin
            count_accum <= accum_next;
            if (count_bits_left != 5'd0) count_bits_left <= count_bits_left - 5'd1;
            if (count_bits_left <= 5'd1) begin
              run_left <= (decode_phase == PH_BITS_N) ? run_sum[15:0] - 16'd1
                                                      : run_sum[15:0];
            end
          end
          default: begin
            if (first_pending) begin
              first_pending <= 1'b0;
              chunk_mask    <= '1;
              col_x         <= 8'd0;
              row_y         <= 7'd0;
              pixel_value   <= bit_in;
              group_count   <= 3'd1;
              decode_phase  <= PH_UNARY;
            end else begin
              chunk_mask <= mask_next;
              if (mask_bits_seen == 6'd63) begin
                mask_bits_seen <= 6'd0;
                col_x          <= 8'd0;
                row_y          <= 7'd0;
                if (mask_next == 64'd0) begin
                  frame_counter <= frame_counter + 16'd1;
                  frame_flag    <= 1'b1;
                  run_left      <= 16'd0;
                  decode_phase  <= PH_MASK;
                end else begin
                  decode_phase <= PH_COLOUR;
                end
              end else begin
                decode_phase   <= PH_MASK;
                mask_bits_seen <= mask_bits_seen + 6'd1;
              end
            end
          end
        endcase
      end
      // pixel written, next row with chunk counters kept in step
      if (cmd.paint_wr) begin
        row_y <= row_y + 7'd1;
        if (row_in_inc == {3'b0, chunk_h}) begin
          row_in  <= 7'd0;
          chunk_y <= chunk_y + 3'd1;
        end else begin
          row_in <= row_in_inc;
        end
      end
      // chunk position by repeated subtraction of the chunk width and height
      if (cmd.sync_start) begin
        col_in  <= col_x;
        chunk_x <= 3'd0;
        row_in  <= row_y;
        chunk_y <= 3'd0;
      end
      if (cmd.sync_step) begin
        if (col_in >= {3'b0, chunk_w}) begin
          col_in  <= col_in - {3'b0, chunk_w};
          chunk_x <= chunk_x + 3'd1;
        end
        if (row_in >= {3'b0, chunk_h}) begin
          row_in  <= row_in - {3'b0, chunk_h};
          chunk_y <= chunk_y + 3'd1;
        end
      end
      if (cmd.walk_step) begin
        if (col_ge) begin
          frame_counter  <= frame_counter + 16'd1;
          frame_flag     <= 1'b1;
          decode_phase   <= PH_MASK;
          mask_bits_seen <= 6'd0;
          col_x          <= 8'd0;
          row_y          <= 7'd0;
          run_left       <= 16'd0;
        end else if (row_ge) begin
          col_x   <= col_x + 8'd1;
          row_y   <= 7'd0;
          row_in  <= 7'd0;
          chunk_y <= 3'd0;
          if (col_in_inc == {3'b0, chunk_w}) begin
            col_in  <= 8'd0;
            chunk_x <= chunk_x + 3'd1;
          end else begin
            col_in <= col_in_inc;
          end
        end else if (skip) begin
          row_y   <= row_y + {3'b0, chunk_h};
          chunk_y <= chunk_y + 3'd1;
        end else if (run_left == 16'd0) begin
          pixel_value  <= ~pixel_value;
          group_count  <= 3'd1;
          decode_phase <= PH_UNARY_N;
        end else begin
          run_left <= run_left - 16'd1;
        end
      end
    end
  end

endmodule

// File: src/crbd_ctrl.sv
// ----------------------------------------------------------------------------
// crbd_ctrl
// sequencer for clearing, reads, bit decode, chunk sync, walk and paint
// ----------------------------------------------------------------------------
`include "chunked_rle_bitmap_decoder_unit_assert.svh"

module crbd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  output logic                  out_valid,
  input  logic                  out_ready,
  output crbd_pkg::crbd_cmd_t   cmd,
  input  crbd_pkg::crbd_stat_t  stat
);
  import crbd_pkg::*;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_RD       = 4'd2;
  localparam logic [3:0] ST_BIT      = 4'd3;
  localparam logic [3:0] ST_PAINT_RD = 4'd4;
  localparam logic [3:0] ST_PAINT_WR = 4'd5;
  localparam logic [3:0] ST_SYNC0    = 4'd6;
  localparam logic [3:0] ST_SYNC     = 4'd7;
  localparam logic [3:0] ST_WALK     = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] bits_done;
  logic [2:0] sync_cnt;
  logic       after_sync;
  logic       out_free;

  always_comb begin
    out_free   = !out_valid || out_ready;
    in_ready   = (state == ST_IDLE);
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = (in_kind == KIND_READ) ? ST_RD : ST_BIT;
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_DONE;
      end
      ST_BIT: begin
        cmd.take_bit = 1'b1;
        if (stat.count_done) begin
          state_next = stat.count_n ? ST_PAINT_RD : ST_SYNC0;
        end else if (bits_done == 4'd7) begin
          state_next = ST_DONE;
        end
      end
      ST_PAINT_RD: begin
        cmd.paint_rd = 1'b1;
        state_next   = ST_PAINT_WR;
      end
      ST_PAINT_WR: begin
        cmd.paint_wr = 1'b1;
        state_next   = after_sync ? ST_SYNC0 : ST_WALK;
      end
      ST_SYNC0: begin
        cmd.sync_start = 1'b1;
        state_next     = ST_SYNC;
      end
      ST_SYNC: begin
        cmd.sync_step = 1'b1;
        if (sync_cnt == 3'd7) state_next = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_paint) begin
          state_next = ST_PAINT_RD;
        end else if (stat.walk_end) begin
          state_next = (bits_done == 4'd8) ? ST_DONE : ST_BIT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      bits_done  <= 4'd0;
      sync_cnt   <= 3'd0;
      after_sync <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_in) bits_done <= 4'd0;
      if (cmd.take_bit) begin
        bits_done  <= bits_done + 4'd1;
        after_sync <= 1'b1;
      end
      if (cmd.walk_step) after_sync <= 1'b0;
      sync_cnt <= cmd.sync_step ? sync_cnt + 3'd1 : 3'd0;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `CRBD_ASSERT_IMP(a_load_free, cmd.out_load && out_valid, out_ready)
  `CRBD_ASSERT_IMP(a_bit_count, state == ST_BIT, bits_done < 4'd8)
  `CRBD_ASSERT_NEXT(a_count_paint, cmd.take_bit && stat.count_done && stat.count_n,
                    state == ST_PAINT_RD && after_sync)
  `CRBD_ASSERT_HOLD(a_no_clear_accept, !(state == ST_CLEAR && in_ready))

endmodule
